// File: design/rtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types and constants of the five-tuple rule table classifier.
// ----------------------------------------------------------------------------
package rtc_pkg;

	// Table size and derived widths.
	localparam int RULE_SLOTS = 64;
	localparam int ID_W       = 16;
	localparam int BIT_W      = $clog2(ID_W);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	// Protocol numbers that get a class of their own.
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	typedef enum logic [1:0] {
		FUNC_CLASSIFY = 2'd0,
		FUNC_ADD      = 2'd1,
		FUNC_DELETE   = 2'd2,
		FUNC_RSVD     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PCLASS_ICMP  = 2'd0,
		PCLASS_TCP   = 2'd1,
		PCLASS_UDP   = 2'd2,
		PCLASS_OTHER = 2'd3
	} pclass_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_UPDATED = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_ABSENT  = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_MIN
	} back_state_t;

	// One decoded command as it travels through the queue.
	typedef struct packed {
		logic [1:0]      func;
		logic [ID_W-1:0] rule_id;
		logic            deny;
		pclass_t         pclass;
		logic [31:0]     src_addr;
		logic [31:0]     dst_addr;
		logic            src_any;
		logic            dst_any;
		logic [15:0]     sport;
		logic [15:0]     dst_port;
	} cmd_t;

	// One stored rule.
	typedef struct packed {
		logic [ID_W-1:0] ident;
		logic            deny;
		pclass_t         pclass;
		logic [31:0]     src_addr;
		logic [31:0]     dst_addr;
		logic            src_wild;
		logic            dst_wild;
		logic [15:0]     sport;
		logic [15:0]     dst_port;
	} rule_t;

	// Queue handshake toward the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_out_t;

	// Reduce a raw IP protocol number to its class.
	function automatic pclass_t proto_class(input logic [7:0] p);
		pclass_t c;
		c = PCLASS_OTHER;
		if (p == PROTO_ICMP) c = PCLASS_ICMP;
		else if (p == PROTO_TCP) c = PCLASS_TCP;
		else if (p == PROTO_UDP) c = PCLASS_UDP;
		return c;
	endfunction

endpackage

// File: design/rtc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_front
// Accepts command beats, decodes the protocol class and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module rtc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [15:0]        rule_id,
	input  logic               deny,
	input  logic [7:0]         protocol,
	input  logic [31:0]        src_addr,
	input  logic [31:0]        dst_addr,
	input  logic               src_any,
	input  logic               dst_any,
	input  logic [15:0]        sport,
	input  logic [15:0]        dst_port,
	input  logic               pop,
	output rtc_pkg::q_out_t    q_out
);
	import rtc_pkg::*;

	cmd_t              cmd;
	cmd_t              qmem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;
	logic              portless;

	// Decode the beat; portless classes see zero ports on classify.
	always_comb begin
		cmd.func     = func;
		cmd.rule_id  = rule_id;
		cmd.deny     = deny;
		cmd.pclass   = proto_class(protocol);
		cmd.src_addr = src_addr;
		cmd.dst_addr = dst_addr;
		cmd.src_any  = src_any;
		cmd.dst_any  = dst_any;
		portless     = (cmd.pclass == PCLASS_ICMP) || (cmd.pclass == PCLASS_OTHER);
		if (func == FUNC_CLASSIFY && portless) begin
			cmd.sport    = '0;
			cmd.dst_port = '0;
		end else begin
			cmd.sport    = sport;
			cmd.dst_port = dst_port;
		end
	end

	assign busy   = (count_q == QCNT_W'(QDEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (count_q != '0);

	assign q_out.valid = (count_q != '0);
	assign q_out.cmd   = qmem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			qmem_q[wr_ptr_q] <= cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

endmodule

// File: design/rtc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_back
// Rule table and execution engine: compares a packet against every slot,
// picks the lowest deny id bit-serially, and performs adds and deletes.
// ----------------------------------------------------------------------------
module rtc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rtc_pkg::q_out_t    q_out,
	output logic               pop,
	output logic               done,
	output logic               drop,
	output logic [15:0]        hit_id,
	output logic [1:0]         status
);
	import rtc_pkg::*;

	back_state_t           state_q;
	back_state_t           state_nx;
	cmd_t                  cur_q;
	rule_t                 rule_q [RULE_SLOTS];
	logic [RULE_SLOTS-1:0] valid_q;
	logic [RULE_SLOTS-1:0] cand_q;
	logic [BIT_W-1:0]      bit_q;
	logic [ID_W-1:0]       hit_q;

	logic [RULE_SLOTS-1:0] match;
	logic [RULE_SLOTS-1:0] id_eq;
	logic [RULE_SLOTS-1:0] free_v;
	logic [RULE_SLOTS-1:0] free_oh;
	logic [RULE_SLOTS-1:0] bit_col;
	logic [RULE_SLOTS-1:0] zeros;
	logic [RULE_SLOTS-1:0] wr_en;
	logic [RULE_SLOTS-1:0] valid_nx;
	logic                  res_en;
	logic                  res_drop;
	logic [ID_W-1:0]       res_hit;
	logic [1:0]            res_stat;
	logic [ID_W-1:0]       hit_nx;

	// Per-slot compare lanes.
	always_comb begin
		for (int s = 0; s < RULE_SLOTS; s++) begin
			match[s] = valid_q[s] && rule_q[s].deny
				&& (rule_q[s].pclass == cur_q.pclass)
				&& (rule_q[s].src_wild || rule_q[s].src_addr == cur_q.src_addr)
				&& (rule_q[s].dst_wild || rule_q[s].dst_addr == cur_q.dst_addr)
				&& (rule_q[s].sport == '0 || rule_q[s].sport == cur_q.sport)
				&& (rule_q[s].dst_port == '0 || rule_q[s].dst_port == cur_q.dst_port);
			id_eq[s]   = valid_q[s] && (rule_q[s].ident == cur_q.rule_id);
			bit_col[s] = rule_q[s].ident[bit_q];
		end
		free_v  = ~valid_q;
		free_oh = free_v & (~free_v + 1'b1);
		zeros   = cand_q & ~bit_col;
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_out.valid) state_nx = ST_CMP;
			end
			ST_CMP: begin
				if (cur_q.func == FUNC_CLASSIFY && match != '0) state_nx = ST_MIN;
				else state_nx = ST_IDLE;
			end
			ST_MIN: begin
				if (bit_q == '0) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Outputs, table writes and result values.
	always_comb begin
		pop      = 1'b0;
		wr_en    = '0;
		valid_nx = valid_q;
		res_en   = 1'b0;
		res_drop = 1'b0;
		res_hit  = '0;
		res_stat = STAT_DONE;
		hit_nx   = {hit_q[ID_W-2:0], (zeros == '0)};
		unique case (state_q)
			ST_IDLE: begin
				pop = q_out.valid;
			end
			ST_CMP: begin
				case (cur_q.func)
					FUNC_CLASSIFY: begin
						res_en = (match == '0);
					end
					FUNC_ADD: begin
						res_en = 1'b1;
						if (id_eq != '0) begin
							wr_en    = id_eq;
							res_stat = STAT_UPDATED;
						end else if (free_v != '0) begin
							wr_en    = free_oh;
						end else begin
							res_stat = STAT_FULL;
						end
						valid_nx = valid_q | wr_en;
					end
					FUNC_DELETE: begin
						res_en = 1'b1;
						if (id_eq != '0) valid_nx = valid_q & ~id_eq;
						else res_stat = STAT_ABSENT;
					end
					default: begin
						res_en = 1'b1;
					end
				endcase
			end
			ST_MIN: begin
				if (bit_q == '0) begin
					res_en   = 1'b1;
					res_drop = 1'b1;
					res_hit  = hit_nx;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_nx;
			valid_q <= valid_nx;
			done    <= res_en;
		end
	end

	// Rule storage.
	always_ff @(posedge clk) begin
		for (int s = 0; s < RULE_SLOTS; s++) begin
			if (wr_en[s]) begin
				rule_q[s].ident    <= cur_q.rule_id;
				rule_q[s].deny     <= cur_q.deny;
				rule_q[s].pclass   <= cur_q.pclass;
				rule_q[s].src_addr <= cur_q.src_addr;
				rule_q[s].dst_addr <= cur_q.dst_addr;
				rule_q[s].src_wild <= cur_q.src_any;
				rule_q[s].dst_wild <= cur_q.dst_any;
				rule_q[s].sport    <= cur_q.sport;
				rule_q[s].dst_port <= cur_q.dst_port;
			end
		end
	end

	// Current command and bit-serial minimum search, MSB first.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_out.cmd;
		end
		if (state_q == ST_CMP) begin
			cand_q <= match;
			bit_q  <= BIT_W'(ID_W - 1);
			hit_q  <= '0;
		end else if (state_q == ST_MIN) begin
			if (zeros != '0) cand_q <= zeros;
			bit_q <= bit_q - 1'b1;
			hit_q <= hit_nx;
		end
		if (res_en) begin
			drop   <= res_drop;
			hit_id <= res_hit;
			status <= res_stat;
		end
	end

endmodule

// File: design/five_tuple_rule_table_classifier.sv
`timescale 1ns / 1ps
// Add, delete and non-matching classify beats raise done after passing the
// queue, the command register and the compare state; a classify that hits a
// deny rule also runs the 16-step bit-serial search for the lowest deny id.
// The back end finishes one beat before it pops the next; a 2-entry queue
// lets new beats enter while the back end works. Results cannot be stalled.
// Reset clears all rule valid marks, the queue and the engine at once.
// ----------------------------------------------------------------------------
// five_tuple_rule_table_classifier
// Five-tuple packet filter with a rule table of add, delete and classify.
// ----------------------------------------------------------------------------
module five_tuple_rule_table_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [15:0] rule_id,
	input  logic        deny,
	input  logic [7:0]  protocol,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic        src_any,
	input  logic        dst_any,
	input  logic [15:0] sport,
	input  logic [15:0] dst_port,
	output logic        done,
	output logic        drop,
	output logic [15:0] hit_id,
	output logic [1:0]  status
);
	import rtc_pkg::*;

	q_out_t q_out;
	logic   pop;

	// Front end with command queue.
	rtc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.rule_id  (rule_id),
		.deny     (deny),
		.protocol (protocol),
		.src_addr (src_addr),
		.dst_addr (dst_addr),
		.src_any  (src_any),
		.dst_any  (dst_any),
		.sport    (sport),
		.dst_port (dst_port),
		.pop      (pop),
		.q_out    (q_out)
	);

	// Back end with the rule table.
	rtc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_out  (q_out),
		.pop    (pop),
		.done   (done),
		.drop   (drop),
		.hit_id (hit_id),
		.status (status)
	);

endmodule
